### design/sqra_pkg.sv
// Shared constants for the stack, queue and return-adjust block.
package sqra_pkg;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 16;
	localparam int DIST_W   = 16;
	localparam int QLEN_W   = 5;
	localparam int STATUS_W = 2;
	localparam int FLAG_W   = 2;
	localparam int TDATA_W  = 40;

	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd2;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd3;
	localparam logic [OP_W-1:0] OP_ADJUST  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### design/sqra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sqra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/stack_queue_return_adjust.sv
// Top level: value stack, non-wrapping log queue and return stack in synchronous RAMs.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser: operation; tdata: push and log fields
//  m_axis   out  m_axis_tvalid / m_axis_tready  tuser: status; tdata: popped, entry, length
//
//  An item has two steps: the accept cycle updates counters and issues the RAM reads
//  and push/enqueue writes, the exec state takes the registered read data, performs the
//  adjust flag write and loads the output register.
//  Reset clears all counters and handshake state; RAM contents are undefined until written.
//  A stalled output holds the block in its exec state; a new word is taken once the
//  result has moved into the output register.
module stack_queue_return_adjust #(
	parameter int STORE_DEPTH = 16,
	parameter int DATA_WIDTH  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// stack_value[15:0], record_return[16], dist_in[32:17], serviced_in[33], full_in[34]
	input  logic [sqra_pkg::TDATA_W-1:0]   s_axis_tdata,
	// operation[2:0]
	input  logic [sqra_pkg::OP_W-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// popped_value[15:0], dist_out[31:16], serviced_out[32], full_out[33], queue_length[38:34]
	output logic [sqra_pkg::TDATA_W-1:0]   m_axis_tdata,
	// status[1:0]
	output logic [sqra_pkg::STATUS_W-1:0]  m_axis_tuser
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [CW-1:0] stack_count_q;
	logic [CW-1:0] return_count_q;
	logic [CW-1:0] queue_tail_q;
	logic [CW-1:0] queue_head_q;

	logic [sqra_pkg::OP_W-1:0]     op_q;
	logic                          srv_q;
	logic                          ful_q;
	logic [sqra_pkg::STATUS_W-1:0] status_q;
	logic [sqra_pkg::QLEN_W-1:0]   qlen_q;

	logic [sqra_pkg::VALUE_W-1:0]  popped_q;
	logic [sqra_pkg::DIST_W-1:0]   dist_out_q;
	logic                          srv_out_q;
	logic                          ful_out_q;
	logic [sqra_pkg::QLEN_W-1:0]   qlen_out_q;
	logic [sqra_pkg::STATUS_W-1:0] status_out_q;
	logic                          m_valid_q;

	logic [sqra_pkg::OP_W-1:0]    op_in;
	logic [sqra_pkg::VALUE_W-1:0] value_in;
	logic                         rec_in;
	logic [sqra_pkg::DIST_W-1:0]  dist_in;
	logic                         srv_in;
	logic                         ful_in;

	logic accept;
	logic out_free;
	logic stk_room, ret_room, q_room, stk_any, ret_any, deq_ok;
	logic [CW-1:0] stk_top, ret_top;
	logic [CW-1:0] stack_count_d, return_count_d, queue_tail_d, queue_head_d;
	logic [sqra_pkg::STATUS_W-1:0] status_d;

	logic                      vs_we, rs_we, dist_we, flag_we, enq_flag_we, adj_we;
	logic                      vs_re, rs_re, q_re;
	logic [AW-1:0]             flag_waddr;
	logic [sqra_pkg::FLAG_W-1:0] flag_wdata;
	logic [DATA_WIDTH-1:0]     vs_rdata;
	logic [CW-1:0]             rs_rdata;
	logic [sqra_pkg::DIST_W-1:0] dist_rdata;
	logic [sqra_pkg::FLAG_W-1:0] flag_rdata;
	logic                      ok_q;

	assign op_in    = s_axis_tuser;
	assign value_in = s_axis_tdata[15:0];
	assign rec_in   = s_axis_tdata[16];
	assign dist_in  = s_axis_tdata[32:17];
	assign srv_in   = s_axis_tdata[33];
	assign ful_in   = s_axis_tdata[34];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign ok_q          = (status_q == sqra_pkg::ST_OK);

	assign stk_room = stack_count_q  < CW'(STORE_DEPTH);
	assign ret_room = return_count_q < CW'(STORE_DEPTH);
	assign q_room   = queue_tail_q   < CW'(STORE_DEPTH);
	assign stk_any  = stack_count_q  != '0;
	assign ret_any  = return_count_q != '0;
	assign deq_ok   = queue_head_q   < queue_tail_q;
	assign stk_top  = stack_count_q  - CW'(1);
	assign ret_top  = return_count_q - CW'(1);

	always_comb begin
		status_d       = sqra_pkg::ST_OK;
		stack_count_d  = stack_count_q;
		return_count_d = return_count_q;
		queue_tail_d   = queue_tail_q;
		queue_head_d   = queue_head_q;
		case (op_in)
			sqra_pkg::OP_PUSH: begin
				if (stk_room) begin
					stack_count_d = stack_count_q + CW'(1);
				end else begin
					status_d = sqra_pkg::ST_FULL;
				end
				if (rec_in) begin
					if (ret_room) begin
						return_count_d = return_count_q + CW'(1);
					end else begin
						status_d = sqra_pkg::ST_FULL;
					end
				end
			end
			sqra_pkg::OP_POP: begin
				if (stk_any) begin
					stack_count_d = stk_top;
				end else begin
					status_d = sqra_pkg::ST_EMPTY;
				end
			end
			sqra_pkg::OP_ENQUEUE: begin
				if (q_room) begin
					queue_tail_d = queue_tail_q + CW'(1);
				end else begin
					status_d = sqra_pkg::ST_FULL;
				end
			end
			sqra_pkg::OP_DEQUEUE: begin
				if (deq_ok) begin
					queue_head_d = queue_head_q + CW'(1);
				end else begin
					status_d = sqra_pkg::ST_EMPTY;
				end
			end
			sqra_pkg::OP_ADJUST: begin
				if (ret_any) begin
					return_count_d = ret_top;
				end else begin
					status_d = sqra_pkg::ST_EMPTY;
				end
			end
			default: begin
				status_d = sqra_pkg::ST_OK;
			end
		endcase
	end

	assign vs_we       = accept && (op_in == sqra_pkg::OP_PUSH) && stk_room;
	assign rs_we       = accept && (op_in == sqra_pkg::OP_PUSH) && rec_in && ret_room;
	assign dist_we     = accept && (op_in == sqra_pkg::OP_ENQUEUE) && q_room;
	assign enq_flag_we = dist_we;
	assign adj_we      = (state_q == S_EXEC) && out_free && (op_q == sqra_pkg::OP_ADJUST)
	                     && ok_q && (rs_rdata < CW'(STORE_DEPTH));
	assign flag_we     = enq_flag_we || adj_we;
	assign flag_waddr  = adj_we ? rs_rdata[AW-1:0] : queue_tail_q[AW-1:0];
	assign flag_wdata  = adj_we ? {srv_q, ful_q} : {srv_in, ful_in};

	assign vs_re = accept && (op_in == sqra_pkg::OP_POP);
	assign q_re  = accept && (op_in == sqra_pkg::OP_DEQUEUE);
	assign rs_re = accept && (op_in == sqra_pkg::OP_ADJUST);

	sqra_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (vs_we),
		.waddr (stack_count_q[AW-1:0]),
		.wdata (DATA_WIDTH'(value_in)),
		.re    (vs_re),
		.raddr (stk_top[AW-1:0]),
		.rdata (vs_rdata)
	);

	sqra_ram #(.WIDTH(CW), .DEPTH(STORE_DEPTH)) u_return_ram (
		.clk   (clk),
		.we    (rs_we),
		.waddr (return_count_q[AW-1:0]),
		.wdata (queue_tail_q),
		.re    (rs_re),
		.raddr (ret_top[AW-1:0]),
		.rdata (rs_rdata)
	);

	sqra_ram #(.WIDTH(sqra_pkg::DIST_W), .DEPTH(STORE_DEPTH)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (queue_tail_q[AW-1:0]),
		.wdata (dist_in),
		.re    (q_re),
		.raddr (queue_head_q[AW-1:0]),
		.rdata (dist_rdata)
	);

	sqra_ram #(.WIDTH(sqra_pkg::FLAG_W), .DEPTH(STORE_DEPTH)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.re    (q_re),
		.raddr (queue_head_q[AW-1:0]),
		.rdata (flag_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			stack_count_q  <= '0;
			return_count_q <= '0;
			queue_tail_q   <= '0;
			queue_head_q   <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						stack_count_q  <= stack_count_d;
						return_count_q <= return_count_d;
						queue_tail_q   <= queue_tail_d;
						queue_head_q   <= queue_head_d;
						state_q        <= S_EXEC;
					end
					if (m_axis_tready) begin
						m_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_in;
			srv_q    <= srv_in;
			ful_q    <= ful_in;
			status_q <= status_d;
			qlen_q   <= sqra_pkg::QLEN_W'(queue_tail_d);
		end
		if ((state_q == S_EXEC) && out_free) begin
			popped_q     <= (op_q == sqra_pkg::OP_POP && ok_q) ?
			                sqra_pkg::VALUE_W'(vs_rdata) : '0;
			dist_out_q   <= (op_q == sqra_pkg::OP_DEQUEUE && ok_q) ? dist_rdata : '0;
			srv_out_q    <= (op_q == sqra_pkg::OP_DEQUEUE && ok_q) && flag_rdata[1];
			ful_out_q    <= (op_q == sqra_pkg::OP_DEQUEUE && ok_q) && flag_rdata[0];
			qlen_out_q   <= qlen_q;
			status_out_q <= status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, qlen_out_q, ful_out_q, srv_out_q, dist_out_q, popped_q};
	assign m_axis_tuser  = status_out_q;

`ifndef SYNTHESIS
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(stack_count_q <= CW'(STORE_DEPTH)) && (return_count_q <= CW'(STORE_DEPTH))
		&& (queue_tail_q <= CW'(STORE_DEPTH)) && (queue_head_q <= queue_tail_q))
		else $error("store counter out of range");

	a_tail_steps: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (queue_tail_q == $past(queue_tail_q))
		|| (queue_tail_q == $past(queue_tail_q) + CW'(1)))
		else $error("queue tail moved by more than one");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (status_out_q == sqra_pkg::ST_EMPTY)
		|-> (popped_q == '0) && (dist_out_q == '0) && !srv_out_q && !ful_out_q)
		else $error("empty result carries data");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(enq_flag_we && adj_we))
		else $error("enqueue and adjust write flags together");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && !out_free |=> (state_q == S_EXEC) && m_valid_q)
		else $error("result lost while output stalled");
`endif

endmodule
